### rtl/slg_pkg.sv
// Shared definitions for the lattice growth step core: parameter defaults,
// event and register codes, register reset values and the direction table.
// No dependencies.
`timescale 1ns / 1ps

package slg_pkg;

  localparam int unsigned MAX_SIDE_DEF   = 32;
  localparam int unsigned COUNT_BITS_DEF = 6;

  // Configuration register reset values.
  localparam logic [5:0] GRID_SIDE_RST    = 6'd16;
  localparam logic       RESTRAIN_RST     = 1'b0;
  localparam logic [5:0] THRESHOLD_RST    = 6'd16;
  localparam logic [3:0] NEIGHBORHOOD_RST = 4'd8;

  typedef enum logic [2:0] {
    EV_EMPTY     = 3'd0,
    EV_NO_GAIN   = 3'd1,
    EV_GAIN      = 3'd2,
    EV_BIRTH     = 3'd3,
    EV_OVERWRITE = 3'd4,
    EV_BLOCKED   = 3'd5,
    EV_REDRAW    = 3'd6,
    EV_STARTED   = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    CFG_GRID_SIDE    = 2'd0,
    CFG_RESTRAIN     = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_NEIGHBORHOOD = 2'd3
  } cfg_idx_t;

  // One step toward a neighbor: left, right, up (row above), down (row below).
  typedef struct packed {
    logic xm;
    logic xp;
    logic ym;
    logic yp;
  } dir_move_t;

  // Direction layout around the cell:  7 2 4 / 0 * 1 / 5 3 6.
  function automatic dir_move_t dir_move(input logic [2:0] dir);
    dir_move_t m;
    m = '0;
    case (dir)
      3'd0: m.xm = 1'b1;
      3'd1: m.xp = 1'b1;
      3'd2: m.ym = 1'b1;
      3'd3: m.yp = 1'b1;
      3'd4: begin m.xp = 1'b1; m.ym = 1'b1; end
      3'd5: begin m.xm = 1'b1; m.yp = 1'b1; end
      3'd6: begin m.xp = 1'b1; m.yp = 1'b1; end
      default: begin m.xm = 1'b1; m.ym = 1'b1; end
    endcase
    return m;
  endfunction

endpackage

### rtl/slg_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module slg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/slg_div.sv
// Iterative restoring divider that splits a linear cell index into row and
// column for a given grid side, one quotient bit per cycle. No dependencies.
`timescale 1ns / 1ps

module slg_div #(
  parameter int unsigned AW = 10,  // dividend width
  parameter int unsigned SW = 6,   // divisor width
  parameter int unsigned QW = 5    // quotient and remainder width
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quot,
  output logic [QW-1:0] rem
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [AW:0]   dsh_r, dsh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          ge;

  assign ge = {1'b0, rem_r} >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      rem_nxt  = dividend;
      dsh_nxt  = (AW + 1)'(divisor) << (QW - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? AW'({1'b0, rem_r} - dsh_r) : rem_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = (q_r << 1) | QW'(ge);
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = QW'(rem_r);

endmodule

### rtl/stochastic_lattice_growth_step_core.sv
// Top level of the lattice growth step core. Uses slg_pkg, slg_ram and slg_div.
// Holds the sequencer, the counters and the configuration registers.
`timescale 1ns / 1ps

// The core keeps one resource count per grid cell in a single RAM and handles
// one request beat at a time. A visit beat runs from acceptance to the result
// beat through reading the source, writing the source and loading the result,
// and when an offspring is placed the target cell is also read and written
// in an extra state over the same RAM. The first visit after reset or after
// grid_side has changed also re-derives the sweep column and row with a
// bit-serial divider. A start beat clears the whole RAM one cell per cycle and
// seeds the center cell during that pass; the same pass runs once after reset,
// during which no request beat is accepted. Configuration writes are taken at
// any time but must only be made while the core is idle. A finished result
// waits until the output register is free and then waits there until taken;
// the core goes idle again once the result has been loaded into that register.
module stochastic_lattice_growth_step_core
  import slg_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = MAX_SIDE_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic        in_coin,
  input  logic [2:0]  in_direction,
  input  logic [9:0]  in_random_cell,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_cell_pos,
  output logic [5:0]  out_cell_value,
  output logic [9:0]  out_target_pos,
  output logic [2:0]  out_event_res,
  output logic [10:0] out_live_count,
  output logic [31:0] out_sweep_count,
  output logic        out_run_done
);

  localparam int unsigned CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned SZ_W      = $clog2(CELLS + 1);
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int unsigned XY_W      = $clog2(MAX_SIDE);
  localparam int unsigned CMP_W     = (COUNT_BITS > 6) ? COUNT_BITS : 6;
  localparam int unsigned RC_W      = (SZ_W > 10) ? SZ_W : 10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_SRC   = 7'b0010000,
    S_TGT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [5:0] grid_side_r;
  logic       restrain_r;
  logic [5:0] threshold_r;
  logic [3:0] nbh_r;

  // Control state.
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               seed_r, seed_nxt;
  logic [ADDR_W-1:0]  sweep_pos_r, sweep_pos_nxt;
  logic [XY_W-1:0]    x_r, x_nxt;
  logic [XY_W-1:0]    y_r, y_nxt;
  logic [SIDE_W-1:0]  trk_side_r, trk_side_nxt;
  logic [SZ_W-1:0]    occ_r, occ_nxt;
  logic [31:0]        sweeps_r, sweeps_nxt;
  logic               pending_r, pending_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-beat working registers.
  logic [ADDR_W-1:0]     cur_pos_r, cur_pos_nxt;
  logic                  redraw_r, redraw_nxt;
  logic                  coin_r, coin_nxt;
  logic [2:0]            dir_r, dir_nxt;
  logic [9:0]            rcell_r, rcell_nxt;
  logic [COUNT_BITS-1:0] src_val_r, src_val_nxt;
  event_t                ev_r, ev_nxt;
  logic [ADDR_W-1:0]     tgt_r, tgt_nxt;

  // Result register.
  logic [9:0]  out_cell_pos_r;
  logic [5:0]  out_cell_value_r;
  logic [9:0]  out_target_pos_r;
  logic [2:0]  out_event_res_r;
  logic [10:0] out_live_count_r;
  logic [31:0] out_sweep_count_r;
  logic        out_run_done_r;
  logic        out_load;

  // RAM ports.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Divider.
  logic            div_start;
  logic            div_done;
  logic [XY_W-1:0] div_quot;
  logic [XY_W-1:0] div_rem;

  // Derived geometry.
  logic [SIDE_W-1:0] side;
  logic [SZ_W-1:0]   size;
  logic [SIDE_W-1:0] half;
  logic [ADDR_W-1:0] center;
  logic              wrap;
  logic [ADDR_W-1:0] pos_eff;
  logic              in_fire;

  // Sweep advance.
  logic [SZ_W-1:0]   adv_p1;
  logic              adv_zero;
  logic [ADDR_W-1:0] adv_pos;
  logic [XY_W-1:0]   adv_x;
  logic [XY_W-1:0]   adv_y;

  // Offspring placement.
  logic                  wmixed;
  dir_move_t             mv;
  logic                  pl_ok;
  logic [ADDR_W:0]       pl_lin;
  logic [ADDR_W-1:0]     pl_tgt;
  logic [COUNT_BITS-1:0] gain_val;
  logic                  at_thr;
  logic                  run_done_now;
  logic                  visit_done;
  logic [COUNT_BITS-1:0] tgt_val;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
      restrain_r  <= RESTRAIN_RST;
      threshold_r <= THRESHOLD_RST;
      nbh_r       <= NEIGHBORHOOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_SIDE:    grid_side_r <= cfg_wdata;
        CFG_RESTRAIN:     restrain_r  <= cfg_wdata[0];
        CFG_THRESHOLD:    threshold_r <= cfg_wdata;
        CFG_NEIGHBORHOOD: nbh_r       <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry. The side in use is grid_side clamped to 1..MAX_SIDE.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (grid_side_r == '0) begin
      side = SIDE_W'(1);
    end else if (int'(grid_side_r) > int'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_side_r);
    end
  end

  assign size    = SZ_W'(side) * SZ_W'(side);
  assign half    = side >> 1;
  assign center  = ADDR_W'(half) + ADDR_W'(half) * ADDR_W'(side);

  // A sweep position left beyond the grid by a smaller side starts over at 0.
  assign wrap    = SZ_W'(sweep_pos_r) >= size;
  assign pos_eff = wrap ? '0 : sweep_pos_r;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Next sweep position. It steps from the raw register, so a redraw whose
  // pending source lay beyond the grid also lands back on cell 0.
  assign adv_p1   = SZ_W'(sweep_pos_r) + SZ_W'(1);
  assign adv_zero = adv_p1 >= size;
  assign adv_pos  = adv_zero ? '0 : ADDR_W'(adv_p1);
  always_comb begin
    if (adv_zero) begin
      adv_x = '0;
      adv_y = '0;
    end else if (SIDE_W'(x_r) + SIDE_W'(1) == side) begin
      adv_x = '0;
      adv_y = y_r + XY_W'(1);
    end else begin
      adv_x = x_r + XY_W'(1);
      adv_y = y_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Offspring placement. Neighbor targets use the tracked column and row of
  // the source; in well-mixed mode the random cell is the target.
  // ---------------------------------------------------------------------------
  assign wmixed = (nbh_r == 4'd0) || (nbh_r > 4'd8);
  assign mv     = dir_move(dir_r);

  always_comb begin
    pl_lin = (ADDR_W + 1)'(cur_pos_r);
    if (mv.xm) pl_lin = pl_lin - (ADDR_W + 1)'(1);
    if (mv.xp) pl_lin = pl_lin + (ADDR_W + 1)'(1);
    if (mv.ym) pl_lin = pl_lin - (ADDR_W + 1)'(side);
    if (mv.yp) pl_lin = pl_lin + (ADDR_W + 1)'(side);
    if (wmixed) begin
      pl_ok  = RC_W'(rcell_r) < RC_W'(size);
      pl_tgt = ADDR_W'(rcell_r);
    end else begin
      pl_ok  = ({1'b0, dir_r} < nbh_r)
               && !(mv.xm && (x_r == '0))
               && !(mv.xp && (SIDE_W'(x_r) + SIDE_W'(1) == side))
               && !(mv.ym && (y_r == '0))
               && !(mv.yp && (SIDE_W'(y_r) + SIDE_W'(1) == side));
      pl_tgt = ADDR_W'(pl_lin);
    end
  end

  // Source count after a gain, saturating at the count maximum.
  assign gain_val   = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign at_thr     = CMP_W'(gain_val) == CMP_W'(threshold_r);
  assign visit_done = (occ_r >= size) && (cur_pos_r == '0) && !pending_r;
  assign run_done_now = (occ_r >= size) && (sweep_pos_r == '0) && !pending_r;

  // A well-mixed target may be the source itself, whose new count has just
  // been written in the previous cycle.
  assign tgt_val = (pl_tgt == cur_pos_r) ? src_val_r : ram_rdata;

  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign div_start = in_fire && in_req_type && !wrap && (trk_side_r != side);

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    seed_nxt      = seed_r;
    sweep_pos_nxt = sweep_pos_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    trk_side_nxt  = trk_side_r;
    occ_nxt       = occ_r;
    sweeps_nxt    = sweeps_r;
    pending_nxt   = pending_r;
    cur_pos_nxt   = cur_pos_r;
    redraw_nxt    = redraw_r;
    coin_nxt      = coin_r;
    dir_nxt       = dir_r;
    rcell_nxt     = rcell_r;
    src_val_nxt   = src_val_r;
    ev_nxt        = ev_r;
    tgt_nxt       = tgt_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_pos_r;
    ram_wdata     = COUNT_BITS'(1);
    ram_raddr     = cur_pos_r;

    unique case (state_r)
      S_CLEAR: begin
        // Zero every cell; a start also seeds the center on the way.
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = (seed_r && (clr_cnt_r == center)) ? COUNT_BITS'(1) : '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
          if (seed_r) begin
            src_val_nxt = COUNT_BITS'(1);
            ev_nxt      = EV_STARTED;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        ram_raddr = pos_eff;
        if (in_fire) begin
          coin_nxt  = in_coin;
          dir_nxt   = in_direction;
          rcell_nxt = in_random_cell;
          if (!in_req_type) begin
            occ_nxt       = SZ_W'(1);
            sweep_pos_nxt = '0;
            sweeps_nxt    = '0;
            pending_nxt   = 1'b0;
            x_nxt         = '0;
            y_nxt         = '0;
            trk_side_nxt  = side;
            seed_nxt      = 1'b1;
            clr_cnt_nxt   = '0;
            cur_pos_nxt   = center;
            state_nxt     = S_CLEAR;
          end else begin
            redraw_nxt  = pending_r;
            cur_pos_nxt = pos_eff;
            if (wrap) begin
              x_nxt        = '0;
              y_nxt        = '0;
              trk_side_nxt = side;
              if (!pending_r) begin
                sweep_pos_nxt = '0;
              end
            end
            if (wrap || (trk_side_r == side)) begin
              state_nxt = S_SRC;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          x_nxt        = div_rem;
          y_nxt        = div_quot;
          trk_side_nxt = side;
          state_nxt    = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_SRC;
      end

      S_SRC: begin
        // Source count is on the read port; the target read goes out now.
        ram_raddr   = pl_tgt;
        src_val_nxt = ram_rdata;
        tgt_nxt     = pl_tgt;
        state_nxt   = S_OUT;
        if (redraw_r) begin
          if (pl_ok) begin
            state_nxt = S_TGT;
          end else begin
            ev_nxt = EV_REDRAW;
          end
        end else if (visit_done) begin
          ev_nxt = EV_EMPTY;
        end else begin
          if ((cur_pos_r == '0) && (sweeps_r != '1)) begin
            sweeps_nxt = sweeps_r + 32'd1;
          end
          if (ram_rdata == '0) begin
            ev_nxt        = EV_EMPTY;
            sweep_pos_nxt = adv_pos;
            x_nxt         = adv_x;
            y_nxt         = adv_y;
          end else if (!coin_r) begin
            ev_nxt        = EV_NO_GAIN;
            sweep_pos_nxt = adv_pos;
            x_nxt         = adv_x;
            y_nxt         = adv_y;
          end else if (at_thr) begin
            ram_we      = 1'b1;
            ram_wdata   = COUNT_BITS'(1);
            src_val_nxt = COUNT_BITS'(1);
            if (pl_ok) begin
              state_nxt = S_TGT;
            end else begin
              // The sweep waits here until a redraw places the offspring.
              ev_nxt      = EV_REDRAW;
              pending_nxt = 1'b1;
            end
          end else begin
            ram_we        = 1'b1;
            ram_wdata     = gain_val;
            src_val_nxt   = gain_val;
            ev_nxt        = EV_GAIN;
            sweep_pos_nxt = adv_pos;
            x_nxt         = adv_x;
            y_nxt         = adv_y;
          end
        end
      end

      S_TGT: begin
        ram_waddr = pl_tgt;
        ram_wdata = COUNT_BITS'(1);
        if (tgt_val == '0) begin
          ram_we  = 1'b1;
          occ_nxt = occ_r + SZ_W'(1);
          ev_nxt  = EV_BIRTH;
        end else if (!restrain_r) begin
          ram_we = 1'b1;
          ev_nxt = EV_OVERWRITE;
        end else begin
          ev_nxt = EV_BLOCKED;
        end
        if (ram_we && (pl_tgt == cur_pos_r)) begin
          src_val_nxt = COUNT_BITS'(1);
        end
        pending_nxt   = 1'b0;
        sweep_pos_nxt = adv_pos;
        x_nxt         = adv_x;
        y_nxt         = adv_y;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers; reset leads into the clearing pass without a seed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      seed_r      <= 1'b0;
      sweep_pos_r <= '0;
      x_r         <= '0;
      y_r         <= '0;
      trk_side_r  <= '0;
      occ_r       <= '0;
      sweeps_r    <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      redraw_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      seed_r      <= seed_nxt;
      sweep_pos_r <= sweep_pos_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      trk_side_r  <= trk_side_nxt;
      occ_r       <= occ_nxt;
      sweeps_r    <= sweeps_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      redraw_r    <= redraw_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_pos_r <= cur_pos_nxt;
    coin_r    <= coin_nxt;
    dir_r     <= dir_nxt;
    rcell_r   <= rcell_nxt;
    src_val_r <= src_val_nxt;
    ev_r      <= ev_nxt;
    tgt_r     <= tgt_nxt;
    if (out_load) begin
      out_cell_pos_r    <= 10'(cur_pos_r);
      out_cell_value_r  <= 6'(src_val_r);
      out_target_pos_r  <= ((ev_r == EV_BIRTH) || (ev_r == EV_OVERWRITE) ||
                            (ev_r == EV_BLOCKED)) ? 10'(tgt_r) : 10'd0;
      out_event_res_r   <= ev_r;
      out_live_count_r  <= 11'(occ_r);
      out_sweep_count_r <= sweeps_r;
      out_run_done_r    <= run_done_now;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_pos    = out_cell_pos_r;
  assign out_cell_value  = out_cell_value_r;
  assign out_target_pos  = out_target_pos_r;
  assign out_event_res   = out_event_res_r;
  assign out_live_count  = out_live_count_r;
  assign out_sweep_count = out_sweep_count_r;
  assign out_run_done    = out_run_done_r;

  // ---------------------------------------------------------------------------
  // Grid memory and the column/row divider.
  // ---------------------------------------------------------------------------
  slg_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slg_div #(
    .AW (ADDR_W),
    .SW (SIDE_W),
    .QW (XY_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sweep_pos_r),
    .divisor  (side),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

endmodule

### tb/tb_stochastic_lattice_growth_step_core.sv
// Self-checking testbench for stochastic_lattice_growth_step_core: a directed table,
// then randomized phases of register settings and request beats, scored against a predictor
// or, for typed table rows, against fixed results. Depends on slg_pkg, the core, its RAM and divider.
`timescale 1ns / 1ps

module tb_stochastic_lattice_growth_step_core;
  import slg_pkg::*;

  localparam int unsigned GRID_MAX   = MAX_SIDE_DEF;
  localparam int unsigned CELL_CNT   = GRID_MAX * GRID_MAX;
  localparam int unsigned COUNT_TOP  = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned ITEMS      = 1750;
  localparam int unsigned QUIET_FROM = ITEMS - 250;
  // A start beat clears the whole RAM, so the few starts dominate the run time.
  // The limit is set well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VISIT = 1'b1;

  typedef struct packed {
    logic [9:0]  cell_pos;
    logic [5:0]  cell_value;
    logic [9:0]  target_pos;
    event_t      event_res;
    logic [10:0] live_count;
    logic [31:0] sweep_count;
    logic        run_done;
  } growth_result_t;

  // One row of the directed table: either a register write or a request beat.
  // When typed is set, want holds the result read straight off the spec.
  typedef struct packed {
    logic           is_cfg;
    cfg_idx_t       reg_idx;
    logic [5:0]     reg_data;
    logic           req_type;
    logic           coin;
    logic [2:0]     direction;
    logic [9:0]     random_cell;
    logic           typed;
    growth_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [5:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic        in_coin;
  logic [2:0]  in_direction;
  logic [9:0]  in_random_cell;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_cell_pos;
  logic [5:0]  out_cell_value;
  logic [9:0]  out_target_pos;
  logic [2:0]  out_event_res;
  logic [10:0] out_live_count;
  logic [31:0] out_sweep_count;
  logic        out_run_done;

  stochastic_lattice_growth_step_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_coin        (in_coin),
    .in_direction   (in_direction),
    .in_random_cell (in_random_cell),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_pos   (out_cell_pos),
    .out_cell_value (out_cell_value),
    .out_target_pos (out_target_pos),
    .out_event_res  (out_event_res),
    .out_live_count (out_live_count),
    .out_sweep_count(out_sweep_count),
    .out_run_done   (out_run_done)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the grid of resource counts, the sweep bookkeeping and a
  // private copy of the four configuration registers.
  // ---------------------------------------------------------------------------
  logic [5:0]  lattice [CELL_CNT];
  int unsigned sweep_at;
  int unsigned live_cells;
  logic [31:0] sweeps_seen;
  logic        retry_due;
  int unsigned retry_src;

  logic [5:0]  cur_side;
  logic        cur_restrain;
  logic [5:0]  cur_threshold;
  logic [3:0]  cur_nbhd;

  growth_result_t predicted_steps[$];
  plan_row_t      plan[$];

  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_pct;
  int unsigned stall_left;
  bit          quiet;

  // The register holds 0..63 but the grid only spans 1..GRID_MAX cells per side.
  function automatic int unsigned side_in_use();
    if (cur_side == 6'd0) return 1;
    if (int'(cur_side) > GRID_MAX) return GRID_MAX;
    return int'(cur_side);
  endfunction

  // The run is finished only when every cell is live, the sweep has wrapped
  // and no offspring is still waiting for a valid draw.
  function automatic bit grid_full(input int unsigned size);
    return live_cells >= size && sweep_at == 0 && !retry_due;
  endfunction

  function automatic void bump_sweep(input int unsigned size);
    sweep_at = (sweep_at + 1 >= size) ? 0 : sweep_at + 1;
  endfunction

  // Places the offspring of src. A neighbor off the grid, a direction the
  // neighborhood does not allow, or a well-mixed draw past the last cell
  // all come back as a redraw with no target.
  function automatic event_t place_offspring(input int unsigned src, input logic [2:0] dir,
                                             input logic [9:0] rcell, input int unsigned side,
                                             output int unsigned tgt);
    int x, y, dx, dy;
    int unsigned size, t;
    size = side * side;
    tgt = 0;
    if (cur_nbhd == 4'd0 || cur_nbhd > 4'd8) begin
      if (int'(rcell) >= size) return EV_REDRAW;
      t = int'(rcell);
    end else begin
      if ({1'b0, dir} >= cur_nbhd) return EV_REDRAW;
      // Layout around the cell: 7 2 4 / 0 * 1 / 5 3 6, with y growing downward.
      case (dir)
        3'd0: begin dx = -1; dy = 0; end
        3'd1: begin dx = 1; dy = 0; end
        3'd2: begin dx = 0; dy = -1; end
        3'd3: begin dx = 0; dy = 1; end
        3'd4: begin dx = 1; dy = -1; end
        3'd5: begin dx = -1; dy = 1; end
        3'd6: begin dx = 1; dy = 1; end
        default: begin dx = -1; dy = -1; end
      endcase
      x = int'(src % side) + dx;
      y = int'(src / side) + dy;
      if (x < 0 || y < 0 || x >= int'(side) || y >= int'(side)) return EV_REDRAW;
      t = x + y * side;
    end
    tgt = t;
    if (lattice[t] == 6'd0) begin
      lattice[t] = 6'd1;
      live_cells++;
      return EV_BIRTH;
    end
    if (!cur_restrain) begin
      lattice[t] = 6'd1;
      return EV_OVERWRITE;
    end
    return EV_BLOCKED;
  endfunction

  // Applies one accepted request beat to the predictor and returns the result
  // beat the core must produce for it.
  function automatic growth_result_t advance_lattice(input logic rt, input logic coin,
                                                     input logic [2:0] dir,
                                                     input logic [9:0] rcell);
    int unsigned side, size, pos, tgt;
    event_t ev;
    growth_result_t r;
    side = side_in_use();
    size = side * side;
    tgt = 0;
    if (rt == REQ_START) begin
      for (int i = 0; i < CELL_CNT; i++) lattice[i] = 6'd0;
      pos = side / 2 + (side / 2) * side;
      lattice[pos] = 6'd1;
      live_cells = 1;
      sweep_at = 0;
      sweeps_seen = '0;
      retry_due = 1'b0;
      retry_src = 0;
      ev = EV_STARTED;
    end else if (retry_due) begin
      // Retry for the stalled source; the coin plays no part here. A source
      // left stale by a smaller grid falls back to cell zero.
      pos = (retry_src >= size) ? 0 : retry_src;
      ev = place_offspring(pos, dir, rcell, side, tgt);
      if (ev != EV_REDRAW) begin
        retry_due = 1'b0;
        bump_sweep(size);
      end
    end else begin
      if (sweep_at >= size) sweep_at = 0;
      pos = sweep_at;
      if (grid_full(size)) begin
        ev = EV_EMPTY;
      end else begin
        if (pos == 0 && sweeps_seen != '1) sweeps_seen++;
        if (lattice[pos] == 6'd0) begin
          ev = EV_EMPTY;
          bump_sweep(size);
        end else if (!coin) begin
          ev = EV_NO_GAIN;
          bump_sweep(size);
        end else begin
          // Counts saturate; thresholds of zero or one can never match.
          if (int'(lattice[pos]) < COUNT_TOP) lattice[pos]++;
          if (lattice[pos] == cur_threshold) begin
            lattice[pos] = 6'd1;
            ev = place_offspring(pos, dir, rcell, side, tgt);
            if (ev == EV_REDRAW) begin
              retry_due = 1'b1;
              retry_src = pos;
            end else begin
              bump_sweep(size);
            end
          end else begin
            ev = EV_GAIN;
            bump_sweep(size);
          end
        end
      end
    end
    r.cell_pos    = 10'(pos);
    r.cell_value  = lattice[pos];
    r.target_pos  = (ev == EV_BIRTH || ev == EV_OVERWRITE || ev == EV_BLOCKED) ? 10'(tgt)
                                                                            : 10'd0;
    r.event_res   = ev;
    r.live_count  = 11'(live_cells);
    r.sweep_count = sweeps_seen;
    r.run_done    = grid_full(size);
    return r;
  endfunction

  function automatic growth_result_t outcome(input int unsigned pos, input int unsigned val,
                                             input int unsigned tgt, input event_t ev,
                                             input int unsigned live, input int unsigned sweeps,
                                             input bit done);
    growth_result_t r;
    r.cell_pos    = 10'(pos);
    r.cell_value  = 6'(val);
    r.target_pos  = 10'(tgt);
    r.event_res   = ev;
    r.live_count  = 11'(live);
    r.sweep_count = 32'(sweeps);
    r.run_done    = done;
    return r;
  endfunction

  function automatic void add_req(input logic rt, input logic coin, input logic [2:0] dir,
                                  input logic [9:0] rcell, input bit typed,
                                  input growth_result_t want);
    plan_row_t row;
    row = '0;
    row.req_type    = rt;
    row.coin        = coin;
    row.direction   = dir;
    row.random_cell = rcell;
    row.typed       = typed;
    row.want        = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_idx_t idx, input logic [5:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All inputs change by nonblocking assignment right after a rising
  // edge, and handshakes are judged on the values that held before that edge.
  // ---------------------------------------------------------------------------

  // Drives one request beat and holds it until accepted. Valid is left high so
  // that back-to-back beats need no second assignment in the same time step.
  task automatic send_req(input logic rt, input logic coin, input logic [2:0] dir,
                          input logic [9:0] rcell, input bit typed,
                          input growth_result_t want);
    growth_result_t pred;
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_coin        <= coin;
    in_direction   <= dir;
    in_random_cell <= rcell;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = advance_lattice(rt, coin, dir, rcell);
    predicted_steps.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Stops sending and waits for every outstanding result beat. The core has
  // gone idle by the time the last result has been handed over.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_steps.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after its last write.
  task automatic put_reg(input cfg_idx_t idx, input logic [5:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_GRID_SIDE:    cur_side = data;
      CFG_RESTRAIN:     cur_restrain = data[0];
      CFG_THRESHOLD:    cur_threshold = data;
      CFG_NEIGHBORHOOD: cur_nbhd = data[3:0];
      default: ;
    endcase
  endtask

  // Receiver: stalls come in bursts, at a rate set per phase.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: every result beat is matched against the oldest prediction.
  always @(posedge clk) begin : score_beat
    growth_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_steps.size() == 0) begin
        $display("%0t: result beat with nothing predicted, expected none, actual cell_pos %0d",
                 $time, out_cell_pos);
        mismatches++;
      end else begin
        want = predicted_steps.pop_front();
        check_field("cell_pos", 32'(want.cell_pos), 32'(out_cell_pos));
        check_field("cell_value", 32'(want.cell_value), 32'(out_cell_value));
        check_field("target_pos", 32'(want.target_pos), 32'(out_target_pos));
        check_field("event_res", 32'(want.event_res), 32'(out_event_res));
        check_field("live_count", 32'(want.live_count), 32'(out_live_count));
        check_field("sweep_count", want.sweep_count, out_sweep_count);
        check_field("run_done", 32'(want.run_done), 32'(out_run_done));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, phase_len, coin_pct, gap_pct, pick, side, size, nb;
    logic [5:0]  sw, rw, tw, nw;
    bit          fresh;
    logic        rt, coin;
    logic [2:0]  dir;
    logic [9:0]  rcell;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_GRID_SIDE;
    cfg_wdata      <= 6'd0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_VISIT;
    in_coin        <= 1'b0;
    in_direction   <= 3'd0;
    in_random_cell <= 10'd0;
    out_ready      <= 1'b0;
    stall_left     = 0;
    stall_pct      = 0;
    quiet          = 1'b0;
    items_sent     = 0;
    mismatches     = 0;
    cycle_count    = 0;

    // Predictor reset state mirrors the core's reset.
    for (int i = 0; i < CELL_CNT; i++) lattice[i] = 6'd0;
    sweep_at      = 0;
    live_cells    = 0;
    sweeps_seen   = '0;
    retry_due     = 1'b0;
    retry_src     = 0;
    cur_side      = GRID_SIDE_RST;
    cur_restrain  = RESTRAIN_RST;
    cur_threshold = THRESHOLD_RST;
    cur_nbhd      = NEIGHBORHOOD_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. The first rows run on the reset settings of a 16 x 16
    // grid, then shrink it to one cell, then to two by two where every case of
    // placement can be provoked within a handful of beats (center is cell 3).
    add_req(REQ_VISIT, 1'b1, 3'd0, 10'd0, 1'b1, outcome(0, 0, 0, EV_EMPTY, 0, 1, 1'b0));
    add_req(REQ_START, 1'b0, 3'd0, 10'd0, 1'b1, outcome(136, 1, 0, EV_STARTED, 1, 0, 1'b0));
    add_cfg(CFG_GRID_SIDE, 6'd0);
    add_req(REQ_START, 1'b1, 3'd7, 10'h3ff, 1'b1, outcome(0, 1, 0, EV_STARTED, 1, 0, 1'b1));
    add_req(REQ_VISIT, 1'b1, 3'd7, 10'h3ff, 1'b1, outcome(0, 1, 0, EV_EMPTY, 1, 0, 1'b1));
    add_cfg(CFG_GRID_SIDE, 6'd2);
    add_cfg(CFG_THRESHOLD, 6'd2);
    add_req(REQ_START, 1'b0, 3'd0, 10'd0, 1'b1, outcome(3, 1, 0, EV_STARTED, 1, 0, 1'b0));
    repeat (3) add_req(REQ_VISIT, 1'b1, 3'd3, 10'd5, 1'b0, '0);
    add_req(REQ_VISIT, 1'b0, 3'd1, 10'd0, 1'b0, '0);     // center holds, no gain
    repeat (3) add_req(REQ_VISIT, 1'b1, 3'd3, 10'd5, 1'b0, '0);
    add_req(REQ_VISIT, 1'b1, 3'd1, 10'd0, 1'b0, '0);     // right edge: redraw
    add_req(REQ_VISIT, 1'b1, 3'd5, 10'd0, 1'b0, '0);     // below the grid: redraw again
    add_req(REQ_VISIT, 1'b0, 3'd7, 10'd0, 1'b0, '0);     // up-left lands on cell 0
    add_req(REQ_VISIT, 1'b1, 3'd1, 10'd0, 1'b0, '0);     // cell 0 splits into cell 1
    add_req(REQ_VISIT, 1'b1, 3'd0, 10'd0, 1'b0, '0);     // cell 1 overwrites cell 0
    add_cfg(CFG_RESTRAIN, 6'h3f);
    add_req(REQ_VISIT, 1'b1, 3'd2, 10'd0, 1'b0, '0);
    add_req(REQ_VISIT, 1'b1, 3'd2, 10'd0, 1'b0, '0);     // offspring blocked
    add_cfg(CFG_NEIGHBORHOOD, 6'h30);
    add_req(REQ_VISIT, 1'b1, 3'd0, 10'h3ff, 1'b0, '0);   // well mixed, draw off the grid
    add_req(REQ_VISIT, 1'b1, 3'd0, 10'd2, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        put_reg(plan[i].reg_idx, plan[i].reg_data);
        cfg_we <= 1'b0;
      end else begin
        send_req(plan[i].req_type, plan[i].coin, plan[i].direction, plan[i].random_cell,
                 plan[i].typed, plan[i].want);
      end
    end

    // Random phases. Each phase drains the core, loads all four registers and
    // usually starts a fresh run; the rest carry the grid over so that stale
    // sweep positions and stale retry sources meet a changed grid size.
    phase = 0;
    while (items_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) sw = 6'($urandom_range(1, 6));
      else if (pick < 85) sw = 6'($urandom_range(7, 12));
      else if (pick < 93) sw = 6'($urandom_range(13, 32));
      else sw = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      rw = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 70) tw = 6'($urandom_range(2, 5));
      else if (pick < 90) tw = 6'($urandom_range(6, 63));
      else tw = 6'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 40) nb = 8;
      else if (pick < 65) nb = 4;
      else if (pick < 80) nb = $urandom_range(1, 7);
      else nb = $urandom_range(9, 16) % 16;
      nw = {2'($urandom_range(0, 3)), 4'(nb)};
      fresh     = ($urandom_range(0, 9) < 6);
      phase_len = $urandom_range(30, 90);
      coin_pct  = 75;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase

      // The first phases pin down the extremes of the registers.
      case (phase)
        0: begin sw = 6'd3; tw = 6'd2; nw = 6'd8; fresh = 1'b1; end
        1: begin sw = 6'd32; tw = 6'd2; nw = 6'd8; fresh = 1'b1; phase_len = 50; end
        2: begin sw = 6'd63; tw = 6'd3; nw = 6'd4; fresh = 1'b0; phase_len = 40; end
        // A threshold of zero is never met, so the live cells climb to the
        // top of the count range and must stay there.
        3: begin
          sw = 6'd2; tw = 6'd0; nw = 6'd8; rw = 6'd0;
          fresh = 1'b1; phase_len = 300; coin_pct = 95;
        end
        4: begin sw = 6'd2; tw = 6'd1; nw = 6'd15; rw = 6'd1; fresh = 1'b0; phase_len = 60; end
        5: begin sw = 6'd0; tw = 6'd63; nw = 6'd0; fresh = 1'b0; phase_len = 30; end
        6: begin sw = 6'd4; tw = 6'd63; nw = 6'd1; fresh = 1'b1; phase_len = 80; end
        7: begin sw = 6'd5; tw = 6'd2; nw = 6'd0; rw = 6'd1; fresh = 1'b1; phase_len = 80; end
        default: ;
      endcase

      drain_results();
      put_reg(CFG_GRID_SIDE, sw);
      put_reg(CFG_RESTRAIN, rw);
      put_reg(CFG_THRESHOLD, tw);
      put_reg(CFG_NEIGHBORHOOD, nw);
      cfg_we <= 1'b0;

      if (fresh)
        send_req(REQ_START, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 10'($urandom_range(0, 1023)), 1'b0, '0);

      for (int n = 0; n < phase_len && items_sent < ITEMS; n++) begin
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 99) == 0) begin
          drain_results();
        end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        side = side_in_use();
        size = side * side;
        rt    = ($urandom_range(0, 199) == 0) ? REQ_START : REQ_VISIT;
        coin  = ($urandom_range(0, 99) < coin_pct);
        // Mostly legal directions so that offspring actually land, with
        // enough wild ones to keep redraws coming.
        if (cur_nbhd >= 4'd1 && cur_nbhd <= 4'd8 && $urandom_range(0, 4) != 0)
          dir = 3'($urandom_range(0, int'(cur_nbhd) - 1));
        else
          dir = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85) rcell = 10'($urandom_range(0, size - 1));
        else rcell = 10'($urandom_range(0, 1023));
        send_req(rt, coin, dir, rcell, 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
